@@ rtl/path_string_hash_defines.svh @@
// Assertion macros for the path string hash block.
// Included by the files that carry concurrent checks; depends on nothing else.
`ifndef PATH_STRING_HASH_DEFINES_SVH
`define PATH_STRING_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define PSH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("path_string_hash: check failed");
`define PSH_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("path_string_hash: check failed");
`else
`define PSH_ASSERT(label, clk, rst, prop)
`define PSH_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/psh_pkg.sv @@
// Package for the path string hash block: constants, queue entry type and
// word classification helpers. Depends on nothing.
`default_nettype none
package psh_pkg;

   localparam int WORD_W = 32;
   localparam int HASH_W = 64;

   localparam logic [31:0] BSL_PATTERN  = 32'h5C5C_5C5C;
   localparam logic [31:0] CASE_MASK    = 32'hDFDF_DFDF;
   localparam logic [31:0] ONES_BYTES   = 32'h0101_0101;
   localparam logic [31:0] HIGH_BITS    = 32'h8080_8080;
   localparam logic [31:0] BSL_TO_SLASH = 32'd45;
   localparam logic [43:0] WORD_MUL     = 44'hFB8_C4D9_6501;
   localparam logic [26:0] ACC_MUL      = 27'h633_D5F1;
   localparam logic [27:0] LEN_MUL_LO   = 28'h2AA_7333;
   localparam logic [27:0] LEN_MUL_HI   = 28'hAE5_0281;

   localparam logic [31:0] LOW_BYTE1 = 32'h0000_8000;
   localparam logic [31:0] LOW_BYTE2 = 32'h0080_0000;
   localparam logic [31:0] LOW_BYTE3 = 32'h8000_0000;

   // One classified request waiting for the accumulator.
   typedef struct packed {
      logic        last;
      logic [63:0] word_term;
      logic [63:0] len_term;
   } psh_entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } psh_qstat_type;

   // Backslash bytes become slash, then case is folded.
   function automatic logic [31:0] normalize_word(input logic [31:0] x);
      logic [31:0] t;
      logic [31:0] hits;
      t    = x ^ BSL_PATTERN;
      hits = ((~t) >> 7) & ((t - ONES_BYTES) >> 7) & ONES_BYTES;
      return (x - BSL_TO_SLASH * hits) & CASE_MASK;
   endfunction

   // High bit of a byte flags a zero byte; only the lowest flag is exact.
   function automatic logic [31:0] zero_flags(input logic [31:0] x);
      return (~x) & (x - ONES_BYTES) & HIGH_BITS;
   endfunction

endpackage
`default_nettype wire

@@ rtl/psh_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on psh_pkg for the payload widths.
`default_nettype none
interface psh_req_if;
   logic                      valid;
   logic                      ready;
   logic [psh_pkg::WORD_W-1:0] word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface psh_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [psh_pkg::HASH_W-1:0] hash_value;
   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

@@ rtl/psh_front.sv @@
// Front end: accepts request words, classifies them, tracks the byte count
// and computes the word and length terms. Depends on psh_pkg and psh_if.
`default_nettype none
module psh_front #(
   parameter int DEPTH = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   psh_req_if.sink                              req_chan,
   input  wire logic [$clog2(DEPTH+1)-1:0]      fill,
   output      logic                            push,
   output      psh_pkg::psh_entry_type          push_entry
);
   import psh_pkg::*;

   localparam int SUM_W  = $clog2(DEPTH + 3);

   logic        accept;
   logic [31:0] norm;
   logic [31:0] zf;
   logic [31:0] low;
   logic [31:0] below;
   logic [1:0]  nbytes;
   logic        last;

   logic [31:0] count_ff, count_in;
   logic        v1_ff, last1_ff;
   logic [31:0] n1_ff, n1_in, len1_ff, len1_in;
   logic        v2_ff, last2_ff;
   logic [59:0] wlo2_ff, whi2_ff, llo2_ff, lhi2_ff;
   logic [63:0] wsum;
   logic [SUM_W-1:0] pending;

   // Credit check: everything in flight must fit in the queue.
   assign pending = SUM_W'(fill) + SUM_W'(v1_ff) + SUM_W'(v2_ff);
   assign req_chan.ready = (pending < SUM_W'(DEPTH));
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      norm  = normalize_word(req_chan.word);
      zf    = zero_flags(req_chan.word);
      last  = (zf != 32'd0);
      low   = zf & (~zf + 32'd1);
      below = low - 32'd1;
      if (low == LOW_BYTE1) begin
         nbytes = 2'd1;
      end else if (low == LOW_BYTE2) begin
         nbytes = 2'd2;
      end else if (low == LOW_BYTE3) begin
         nbytes = 2'd3;
      end else begin
         nbytes = 2'd0;
      end
      n1_in   = last ? (norm & below) : norm;
      len1_in = count_ff + {30'd0, nbytes};
      count_in = count_ff;
      if (accept) begin
         count_in = last ? 32'd0 : count_ff + 32'd4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         v1_ff    <= accept;
         v2_ff    <= v1_ff;
      end
   end

   // Payload stages; split products keep each multiplier near 32 bits.
   always_ff @(posedge clock) begin
      last1_ff <= last;
      n1_ff    <= n1_in;
      len1_ff  <= len1_in;
      last2_ff <= last1_ff;
      wlo2_ff  <= {16'd0, WORD_MUL} * {44'd0, n1_ff[15:0]};
      whi2_ff  <= {16'd0, WORD_MUL} * {44'd0, n1_ff[31:16]};
      llo2_ff  <= {28'd0, len1_ff} * {32'd0, LEN_MUL_LO};
      lhi2_ff  <= {28'd0, len1_ff} * {32'd0, LEN_MUL_HI};
   end

   assign wsum = {4'd0, wlo2_ff} + {whi2_ff[47:0], 16'd0};

   assign push                 = v2_ff;
   assign push_entry.last      = last2_ff;
   assign push_entry.word_term = {24'd0, wsum[63:24]};
   assign push_entry.len_term  = {4'd0, llo2_ff} + {lhi2_ff[35:0], 28'd0};

endmodule
`default_nettype wire

@@ rtl/psh_queue.sv @@
// Short queue between front and back ends, built from registers.
// Depends on psh_pkg.
`default_nettype none
module psh_queue #(
   parameter int DEPTH = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire psh_pkg::psh_entry_type      push_entry,
   input  wire logic                        pop,
   output      psh_pkg::psh_entry_type      head,
   output      psh_pkg::psh_qstat_type      qstat,
   output      logic [$clog2(DEPTH+1)-1:0]  fill
);
   import psh_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   psh_entry_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign head            = mem_ff[rd_ff];
   assign fill            = fill_ff;
   assign qstat.not_empty = (fill_ff != '0);
   assign qstat.full      = (fill_ff == FILL_W'(DEPTH));

endmodule
`default_nettype wire

@@ rtl/psh_back.sv @@
// Back end: runs the accumulator recurrence and holds the result register.
// Depends on psh_pkg and psh_if.
`default_nettype none
module psh_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire psh_pkg::psh_entry_type  head,
   input  wire psh_pkg::psh_qstat_type  qstat,
   output      logic                    pop,
   psh_rsp_if.source                    rsp_chan
);
   import psh_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] hash_ff, hash_in;
   logic [58:0] prod_lo, prod_hi;
   logic [63:0] prod;
   logic [63:0] sum;

   // A string end may only leave when the result register frees up.
   assign pop = qstat.not_empty && (!head.last || !rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      prod_lo = {27'd0, acc_ff[31:0]} * {32'd0, ACC_MUL};
      prod_hi = {27'd0, acc_ff[63:32]} * {32'd0, ACC_MUL};
      prod    = {5'd0, prod_lo} + {prod_hi[31:0], 32'd0};
      sum     = prod + head.word_term;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (pop) begin
         if (head.last) begin
            acc_in       = '0;
            hash_in      = sum - head.len_term;
            rsp_valid_in = 1'b1;
         end else begin
            acc_in = sum ^ {61'd0, sum[63:61]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hash_value = hash_ff;

endmodule
`default_nettype wire

@@ rtl/path_string_hash.sv @@
// Path string hash, top level; built from psh_pkg, psh_if, psh_front, psh_queue and psh_back.
// A request word is accepted every cycle while the queue has credit for it. The hash of a
// terminating request passes, after the edge that accepts it, through two front
// stages (normalize, split multiplies), the queue entry, then the result register.
// The accumulator takes one request per cycle; only a string end waits on a held result.
// Synchronous reset empties pipeline and queue and clears accumulator, count and result valid.
`default_nettype none
module path_string_hash #(
   parameter int DEPTH = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   psh_req_if.sink   req_chan,
   psh_rsp_if.source rsp_chan
);
   import psh_pkg::*;
`include "path_string_hash_defines.svh"

   localparam int FILL_W = $clog2(DEPTH + 1);

   // Classified requests flow from the front end into the queue.
   logic               q_push;
   psh_entry_type      q_entry;
   // The back end drains the queue head, one request per cycle unless a string end waits on a held result.
   logic               q_pop;
   psh_entry_type      q_head;
   psh_qstat_type      q_stat;
   logic [FILL_W-1:0]  q_fill;

   // The front end normalizes each word, finds the terminator, keeps the
   // running byte count and forms the word and length terms. It takes a
   // request only when the queue can hold everything already in flight, so
   // its pipeline never has to stall.
   psh_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .fill       (q_fill),
      .push       (q_push),
      .push_entry (q_entry)
   );

   // The queue lets the front keep accepting while a result waits downstream.
   psh_queue #(.DEPTH(DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .qstat      (q_stat),
      .fill       (q_fill)
   );

   // The back end folds each word into the accumulator and, on the string
   // end, subtracts the length term and loads the result register.
   psh_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .qstat    (q_stat),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   // The credit check must keep the queue from ever overflowing.
   `PSH_ASSERT(a_queue_no_overflow, clock, reset, q_push |-> (!q_stat.full || q_pop))
   // A result appears only right after a string end left the queue.
   `PSH_ASSERT(a_result_from_last, clock, reset, $rose(rsp_chan.valid) |-> $past(q_pop && q_head.last))
   // Reset leaves no result pending and an empty queue.
   `PSH_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_chan.valid && q_fill == '0))

endmodule
`default_nettype wire
